/* src/vsnm_pkg.sv */
// ----------------------------------------------------------------------------
// vsnm_pkg
// shared types and codes of the voxel cell store: request kinds and the
// payload layouts of the request and response channels
// ----------------------------------------------------------------------------
package vsnm_pkg;

   localparam int COORD_W = 4;
   localparam int DATA_W  = 21;
   localparam int FLAG_W  = 6;
   localparam int VALUE_W = DATA_W + FLAG_W;
   localparam int COUNT_W = 13;

   typedef enum logic [1:0] {
      KIND_SET     = 2'd0,
      KIND_GET     = 2'd1,
      KIND_SCAN    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [COORD_W-1:0]   pos_x;
      logic [COORD_W-1:0]   pos_y;
      logic [COORD_W-1:0]   pos_z;
      logic [DATA_W-1:0]    block_data;
   } req_type;

   typedef struct packed {
      logic                 present;
      logic [COORD_W-1:0]   out_x;
      logic [COORD_W-1:0]   out_y;
      logic [COORD_W-1:0]   out_z;
      logic [VALUE_W-1:0]   packed_value;
      logic [COUNT_W-1:0]   block_count;
      logic                 scan_end;
   } rsp_type;

endpackage

/* src/vsnm_chan_if.sv */
// ----------------------------------------------------------------------------
// vsnm_chan_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface vsnm_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

/* src/voxel_store_neighbor_mask_top.sv */
// ----------------------------------------------------------------------------
// voxel_store_neighbor_mask_top
// set, get, restart and a scan at the end: the request is registered, then the row read
// result, then the response; scan: one occupancy row searched per cycle, a hit adds four
// neighbor row reads and a merge step; a new request is taken once the result is loaded
// a result that finds the output register still full waits, and so does the next request
// reset: clears all CHUNK_SIDE*CHUNK_SIDE occupancy rows, req_chan.ready low until done
// ----------------------------------------------------------------------------
module voxel_store_neighbor_mask_top #(
   parameter int CHUNK_SIDE = 16
) (
   input  logic        clock,
   input  logic        reset,
   vsnm_chan_if.sink   req_chan,
   vsnm_chan_if.source rsp_chan
);

   import vsnm_pkg::*;

   // geometry: a row is one x line of cells at a fixed (y, z)
   localparam int CW    = $clog2(CHUNK_SIDE);
   localparam int YW    = $clog2(CHUNK_SIDE + 1);
   localparam int ROWS  = CHUNK_SIDE * CHUNK_SIDE;
   localparam int RW    = $clog2(ROWS);
   localparam int CELLS = ROWS * CHUNK_SIDE;
   localparam int CLW   = $clog2(CELLS);
   localparam int CNTW  = $clog2(CELLS + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_NBR,
      ST_DONE
   } state_type;

   // memories: occupancy rows and cell data words
   logic [CHUNK_SIDE-1:0] occ_mem [ROWS];
   logic [DATA_W-1:0]     data_mem [CELLS];

   logic [CHUNK_SIDE-1:0] occ_rd_ff;
   logic [DATA_W-1:0]     data_rd_ff;

   // control and captured request
   state_type             state_ff;
   kind_type              kind_ff;
   logic [COORD_W-1:0]    x_ff;
   logic [COORD_W-1:0]    y_ff;
   logic [COORD_W-1:0]    z_ff;
   logic [DATA_W-1:0]     data_ff;
   logic                  inside_ff;
   logic [RW-1:0]         row_ff;
   logic [CLW-1:0]        cell_ff;

   // scan cursor, y == CHUNK_SIDE marks the end
   logic [CW-1:0]         cur_x_ff;
   logic [CW-1:0]         cur_z_ff;
   logic [YW-1:0]         cur_y_ff;

   // found cell and neighbour gathering
   logic [CW-1:0]         hit_x_ff;
   logic [CW-1:0]         hit_y_ff;
   logic [CW-1:0]         hit_z_ff;
   logic [RW-1:0]         hit_row_ff;
   logic [2:0]            nb_ff;
   logic [FLAG_W-1:0]     flags_ff;

   logic [RW-1:0]         clr_ff;
   logic [CNTW-1:0]       count_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   rsp_type               res_ff;

   // ---------------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------------
   logic                  accept;
   logic                  req_inside;
   logic [CW+3:0]         req_x_ext;
   logic [CW+3:0]         req_y_ext;
   logic [CW+3:0]         req_z_ext;
   logic [RW-1:0]         req_row;
   logic [CLW-1:0]        req_cell;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      req_inside = (int'(req_chan.payload.pos_x) < CHUNK_SIDE) &&
                   (int'(req_chan.payload.pos_y) < CHUNK_SIDE) &&
                   (int'(req_chan.payload.pos_z) < CHUNK_SIDE);
      req_x_ext  = (CW+4)'(req_chan.payload.pos_x);
      req_y_ext  = (CW+4)'(req_chan.payload.pos_y);
      req_z_ext  = (CW+4)'(req_chan.payload.pos_z);
      // outside cells only read a harmless entry, writes are gated later
      if (req_inside) begin
         req_row  = RW'(int'(req_y_ext[CW-1:0]) * CHUNK_SIDE + int'(req_z_ext[CW-1:0]));
         req_cell = CLW'(int'(req_row) * CHUNK_SIDE + int'(req_x_ext[CW-1:0]));
      end else begin
         req_row  = '0;
         req_cell = '0;
      end
   end

   // ---------------------------------------------------------------------
   // scan cursor and row search
   // ---------------------------------------------------------------------
   logic                  cur_end;
   logic [RW-1:0]         cur_row;
   logic [CHUNK_SIDE-1:0] keep;
   logic [CHUNK_SIDE-1:0] masked;
   logic                  found;
   logic [CW-1:0]         fx;
   logic [CHUNK_SIDE+1:0] side_bits;
   logic                  z_last;
   logic [CW-1:0]         next_z;
   logic [YW-1:0]         next_y;
   logic                  next_end;
   logic [RW-1:0]         next_row;
   logic [CLW-1:0]        hit_cell;

   always_comb begin
      cur_end = (cur_y_ff == YW'(CHUNK_SIDE));
      cur_row = cur_end ? '0
              : RW'(int'(cur_y_ff[CW-1:0]) * CHUNK_SIDE + int'(cur_z_ff));

      // drop the cells in front of the cursor, then take the lowest set bit
      for (int i = 0; i < CHUNK_SIDE; i++) begin
         keep[i] = (i >= int'(cur_x_ff));
      end
      masked = occ_rd_ff & keep;
      found  = |masked;
      fx     = '0;
      for (int i = CHUNK_SIDE - 1; i >= 0; i--) begin
         if (masked[i]) begin
            fx = CW'(i);
         end
      end

      // bit 0 is the -x neighbour, bit 2 the +x neighbour, zero past the edge
      side_bits = {1'b0, occ_rd_ff, 1'b0} >> fx;

      // next row in scan order: z first, then y
      z_last   = (cur_z_ff == CW'(CHUNK_SIDE - 1));
      next_z   = z_last ? '0 : cur_z_ff + CW'(1);
      next_y   = z_last ? cur_y_ff + YW'(1) : cur_y_ff;
      next_end = (next_y == YW'(CHUNK_SIDE));
      next_row = next_end ? '0
               : RW'(int'(next_y[CW-1:0]) * CHUNK_SIDE + int'(next_z));
      hit_cell = CLW'(int'(cur_row) * CHUNK_SIDE + int'(fx));
   end

   // ---------------------------------------------------------------------
   // neighbour rows: 0 +z, 1 -z, 2 +y, 3 -y
   // ---------------------------------------------------------------------
   logic [3:0]            nb_ok;
   logic [RW-1:0]         nb_addr;
   logic [1:0]            cap_idx;
   logic                  cap_bit;
   logic [FLAG_W-1:0]     flags_new;

   always_comb begin
      nb_ok[0] = (hit_z_ff != CW'(CHUNK_SIDE - 1));
      nb_ok[1] = (hit_z_ff != '0);
      nb_ok[2] = (hit_y_ff != CW'(CHUNK_SIDE - 1));
      nb_ok[3] = (hit_y_ff != '0);

      case (nb_ff[1:0])
         2'd0:    nb_addr = RW'(int'(hit_row_ff) + 1);
         2'd1:    nb_addr = RW'(int'(hit_row_ff) - 1);
         2'd2:    nb_addr = RW'(int'(hit_row_ff) + CHUNK_SIDE);
         default: nb_addr = RW'(int'(hit_row_ff) - CHUNK_SIDE);
      endcase
      if (!nb_ok[nb_ff[1:0]] || (nb_ff == 3'd4)) begin
         nb_addr = hit_row_ff;
      end

      // the row read in the previous step lands now
      cap_idx   = 2'(nb_ff - 3'd1);
      cap_bit   = (nb_ff != 3'd0) && nb_ok[cap_idx] && occ_rd_ff[hit_x_ff];
      flags_new = flags_ff | (FLAG_W'(cap_bit) << (nb_ff + 3'd1));
   end

   // ---------------------------------------------------------------------
   // set / get decode on the returned row
   // ---------------------------------------------------------------------
   logic [CW+3:0]         x_ext;
   logic                  cell_full;
   logic                  set_new;
   logic [CNTW-1:0]       count_next;

   always_comb begin
      x_ext      = (CW+4)'(x_ff);
      cell_full  = inside_ff && occ_rd_ff[x_ext[CW-1:0]];
      set_new    = (state_ff == ST_LOOK) && (kind_ff == KIND_SET) &&
                   inside_ff && !cell_full;
      count_next = count_ff + CNTW'(set_new);
   end

   // ---------------------------------------------------------------------
   // memory ports
   // ---------------------------------------------------------------------
   logic                  occ_we;
   logic [RW-1:0]         occ_waddr;
   logic [CHUNK_SIDE-1:0] occ_wdata;
   logic [RW-1:0]         occ_raddr;
   logic                  data_we;
   logic                  data_re;
   logic [CLW-1:0]        data_raddr;

   always_comb begin
      occ_we    = 1'b0;
      occ_waddr = row_ff;
      occ_wdata = occ_rd_ff | (CHUNK_SIDE'(1) << x_ext[CW-1:0]);
      if (state_ff == ST_CLEAR) begin
         occ_we    = 1'b1;
         occ_waddr = clr_ff;
         occ_wdata = '0;
      end else if ((state_ff == ST_LOOK) && (kind_ff == KIND_SET) && inside_ff) begin
         occ_we = 1'b1;
      end
      data_we = (state_ff == ST_LOOK) && (kind_ff == KIND_SET) && inside_ff;

      case (state_ff)
         ST_IDLE: begin
            occ_raddr = (req_chan.payload.kind == KIND_SCAN) ? cur_row : req_row;
         end
         ST_SCAN: occ_raddr = next_row;
         ST_NBR:  occ_raddr = nb_addr;
         default: occ_raddr = '0;
      endcase

      data_re    = accept || ((state_ff == ST_SCAN) && found);
      data_raddr = (state_ff == ST_SCAN) ? hit_cell : req_cell;
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      occ_rd_ff <= occ_mem[occ_raddr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[cell_ff] <= data_ff;
      end
      if (data_re) begin
         data_rd_ff <= data_mem[data_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // result of the current item
   // ---------------------------------------------------------------------
   logic                  res_go;
   rsp_type               res_in;
   logic [CW+3:0]         hx_ext;
   logic [CW+3:0]         hy_ext;
   logic [CW+3:0]         hz_ext;
   logic [CNTW+12:0]      count_ext;
   logic                  out_free;
   logic                  rsp_load;

   always_comb begin
      hx_ext    = (CW+4)'(hit_x_ff);
      hy_ext    = (CW+4)'(hit_y_ff);
      hz_ext    = (CW+4)'(hit_z_ff);
      count_ext = (CNTW+13)'(count_next);
      out_free  = !rsp_valid_ff || rsp_chan.ready;

      // default: echoed coordinates, nothing found
      res_in.present      = 1'b0;
      res_in.out_x        = x_ff;
      res_in.out_y        = y_ff;
      res_in.out_z        = z_ff;
      res_in.packed_value = '0;
      res_in.block_count  = count_ext[COUNT_W-1:0];
      res_in.scan_end     = 1'b0;
      res_go              = 1'b0;

      case (state_ff)
         ST_LOOK: begin
            res_go = 1'b1;
            case (kind_ff)
               KIND_SET: begin
                  res_in.present      = inside_ff;
                  res_in.packed_value = inside_ff ? VALUE_W'(data_ff) : '0;
               end
               KIND_GET: begin
                  res_in.present      = cell_full;
                  res_in.packed_value = cell_full ? VALUE_W'(data_rd_ff) : '0;
               end
               // scan only comes here with the cursor already at the end
               KIND_SCAN: res_in.scan_end = 1'b1;
               default:   res_in.present  = 1'b0;
            endcase
         end
         ST_SCAN: begin
            // search ran off the last row
            if (!found && next_end) begin
               res_go          = 1'b1;
               res_in.scan_end = 1'b1;
            end
         end
         ST_NBR: begin
            if (nb_ff == 3'd4) begin
               res_go              = 1'b1;
               res_in.present      = 1'b1;
               res_in.out_x        = hx_ext[COORD_W-1:0];
               res_in.out_y        = hy_ext[COORD_W-1:0];
               res_in.out_z        = hz_ext[COORD_W-1:0];
               res_in.packed_value = {flags_new, data_rd_ff};
            end
         end
         default: res_go = 1'b0;
      endcase

      // output register takes a fresh or a parked result
      rsp_load = out_free && (res_go || (state_ff == ST_DONE));
   end

   // ---------------------------------------------------------------------
   // sequencer, cursor, count and output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_z_ff     <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + RW'(1);
               if (clr_ff == RW'(ROWS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  kind_ff   <= req_chan.payload.kind;
                  x_ff      <= req_chan.payload.pos_x;
                  y_ff      <= req_chan.payload.pos_y;
                  z_ff      <= req_chan.payload.pos_z;
                  data_ff   <= req_chan.payload.block_data;
                  inside_ff <= req_inside;
                  row_ff    <= req_row;
                  cell_ff   <= req_cell;
                  if ((req_chan.payload.kind == KIND_SCAN) && !cur_end) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_LOOK;
                  end
               end
            end
            ST_LOOK: begin
               count_ff <= count_next;
               if (kind_ff == KIND_RESTART) begin
                  cur_x_ff <= '0;
                  cur_y_ff <= '0;
                  cur_z_ff <= '0;
               end
            end
            ST_SCAN: begin
               if (found) begin
                  hit_x_ff   <= fx;
                  hit_y_ff   <= cur_y_ff[CW-1:0];
                  hit_z_ff   <= cur_z_ff;
                  hit_row_ff <= cur_row;
                  flags_ff   <= {4'b0000, side_bits[0], side_bits[2]};
                  nb_ff      <= '0;
                  state_ff   <= ST_NBR;
                  // cursor moves past the found cell
                  if (fx == CW'(CHUNK_SIDE - 1)) begin
                     cur_x_ff <= '0;
                     cur_z_ff <= next_z;
                     cur_y_ff <= next_y;
                  end else begin
                     cur_x_ff <= fx + CW'(1);
                  end
               end else begin
                  // empty remainder of the row: go on with the next one
                  cur_x_ff <= '0;
                  cur_z_ff <= next_z;
                  cur_y_ff <= next_y;
               end
            end
            ST_NBR: begin
               nb_ff    <= nb_ff + 3'd1;
               flags_ff <= flags_new;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // hand the result to the output register, or park it
         if (res_go) begin
            if (out_free) begin
               rsp_ff   <= res_in;
               state_ff <= ST_IDLE;
            end else begin
               res_ff   <= res_in;
               state_ff <= ST_DONE;
            end
         end

         // response valid: set on a load, cleared once taken downstream
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule
